// File: sv/console_command_line_matcher_defines.svh
// assertion macros for the console command line matcher
// no dependencies; included by the files that carry assertions
`ifndef CONSOLE_COMMAND_LINE_MATCHER_DEFINES_SVH
`define CONSOLE_COMMAND_LINE_MATCHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CCLM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (prop)) else $error(msg);
`define CCLM_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (pre) |=> (post)) else $error(msg);
`else
`define CCLM_ASSERT(lbl, clk, rst, prop, msg)
`define CCLM_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// File: sv/cclm_pkg.sv
// character codes, sequencer states and the entry compare function
// no dependencies; used by the matcher top level
package cclm_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChDelete  = 8'h7F;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam logic OpKey      = 1'b0;
  localparam logic OpRegister = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_SRCH = 5'b00100,
    S_CRLF = 5'b01000,
    S_SEND = 5'b10000
  } state_e;

  // agree on every position that both texts have; entry ends at first zero
  function automatic logic entry_match(logic [63:0] e, logic [63:0] a, logic [3:0] alen);
    logic       ok;
    logic       found;
    logic [3:0] elen;
    elen  = 4'd8;
    found = 1'b0;
    ok    = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (!found && e[k*8 +: 8] == 8'h00) begin
        elen  = 4'(k);
        found = 1'b1;
      end
    end
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < alen && 4'(k) < elen && e[k*8 +: 8] != a[k*8 +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// File: sv/console_command_line_matcher.sv
// an echo item is offered in the cycle after its keystroke is accepted;
// a return scans the line a character at a time; a line that starts with a
// percent sign is searched by reading each valid table entry in turn, and on a
// match the line is sent to that process, else a CR and LF go to the console.
// one item at a time; reset clears line count, table valid bits and sequencer
// uses cclm_pkg, cclm_ram and the assertion macro header
`include "console_command_line_matcher_defines.svh"
module console_command_line_matcher #(
  parameter int LINE_CHARS    = 32,
  parameter int TABLE_ENTRIES = 8,
  parameter int COMMAND_CHARS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key_char[7:0], command_text[63:8], command_length[66:64], sender_id[70:67]
  input  logic [71:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // process_id[3:0], out_char[11:4]
  output logic [15:0] m_axis_tdata,
  // destination[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import cclm_pkg::*;

  localparam int CW = $clog2(LINE_CHARS);
  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, j_q, j_d, eff_q, eff_d;
  logic [EW:0]   e_q, e_d;
  logic          pend_q, pend_d, mode_line_q, mode_line_d, lf_q, lf_d;
  logic [63:0]   abuf_q, abuf_d;
  logic [3:0]    alen_q, alen_d, owner_q, owner_d, pid_q, pid_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic          out_valid_q, out_valid_d, out_dest_q, out_dest_d, out_last_q, out_last_d;
  logic [3:0]    out_pid_q, out_pid_d;
  logic [7:0]    out_char_q, out_char_d;

  logic          lm_we;
  logic [CW-1:0] lm_waddr, lm_raddr;
  logic [7:0]    lm_wdata, lm_rdata;
  logic          tm_we;
  logic [EW-1:0] tm_raddr, free_slot;
  logic [67:0]   tm_rdata;

  logic          in_acc;
  logic [7:0]    key;
  logic [55:0]   ctext;
  logic [2:0]    clen, reg_n;
  logic [63:0]   reg_buf;
  logic          reg_ok, tbl_full, stop, last_char;

  assign key      = s_axis_tdata[7:0];
  assign ctext    = s_axis_tdata[63:8];
  assign clen     = s_axis_tdata[66:64];
  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign tbl_full = &valid_q;

  cclm_ram #(.WIDTH(8), .DEPTH(LINE_CHARS), .AW(CW)) u_line_ram (
    .clk_i, .we_i(lm_we), .waddr_i(lm_waddr), .wdata_i(lm_wdata),
    .raddr_i(lm_raddr), .rdata_o(lm_rdata)
  );

  cclm_ram #(.WIDTH(68), .DEPTH(TABLE_ENTRIES), .AW(EW)) u_table_ram (
    .clk_i, .we_i(tm_we), .waddr_i(free_slot), .wdata_i({owner_q, abuf_q}),
    .raddr_i(tm_raddr), .rdata_o(tm_rdata)
  );

  // command text up to its length or first zero, then a trailing space
  always_comb begin
    reg_n = 3'd0;
    stop  = 1'b0;
    for (int k = 0; k < 7; k++) begin
      if (!stop && 3'(k) < clen && ctext[k*8 +: 8] != 8'h00) reg_n = 3'(k + 1);
      else stop = 1'b1;
    end
    for (int k = 0; k < 8; k++) begin
      if (k < 7 && 3'(k) < reg_n) reg_buf[k*8 +: 8] = ctext[(k % 7)*8 +: 8];
      else if (4'(k) == {1'b0, reg_n}) reg_buf[k*8 +: 8] = ChSpace;
      else reg_buf[k*8 +: 8] = 8'h00;
    end
    reg_ok = reg_n >= 3'd2 && 32'(reg_n) <= COMMAND_CHARS &&
             ctext[7:0] == ChPercent && ctext[15:8] != ChSpace;
  end

  always_comb begin
    free_slot = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_slot = EW'(i);
    end
  end

  assign last_char = ({1'b0, j_q} + 1'b1) == {1'b0, eff_q};

  always_comb begin
    state_d = state_q;      count_d = count_q;   j_d = j_q;     eff_d = eff_q;
    e_d = e_q;              pend_d = pend_q;     mode_line_d = mode_line_q;
    lf_d = lf_q;            abuf_d = abuf_q;     alen_d = alen_q;
    owner_d = owner_q;      pid_d = pid_q;       valid_d = valid_q;
    out_valid_d = out_valid_q; out_dest_d = out_dest_q; out_last_d = out_last_q;
    out_pid_d = out_pid_q;  out_char_d = out_char_q;
    lm_we = 1'b0;  lm_waddr = count_q;  lm_wdata = key;  lm_raddr = j_q;
    tm_we = 1'b0;  tm_raddr = e_q[EW-1:0];

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == OpRegister) begin
            if (reg_ok && !tbl_full) begin
              abuf_d = reg_buf;
              alen_d = {1'b0, reg_n} + 4'd1;
              owner_d = s_axis_tdata[70:67];
              mode_line_d = 1'b0;
              e_d = '0;
              pend_d = 1'b0;
              state_d = S_SRCH;
            end
          end else begin
            priority if (key == ChCr) begin
              j_d = '0;
              pend_d = 1'b0;
              state_d = S_SCAN;
            end else if (key == ChDelete) begin
              if (count_q != '0) begin
                count_d = count_q - 1'b1;
                lm_we = 1'b1;
                lm_waddr = count_q - 1'b1;
                lm_wdata = 8'h00;
              end
              out_valid_d = 1'b1; out_dest_d = 1'b0; out_pid_d = '0;
              out_char_d = ChDelete; out_last_d = 1'b1;
            end else begin
              if (32'(count_q) < LINE_CHARS - 1) begin
                lm_we = 1'b1;
                count_d = count_q + 1'b1;
                out_valid_d = 1'b1; out_dest_d = 1'b0; out_pid_d = '0;
                out_char_d = key; out_last_d = 1'b1;
              end
            end
          end
        end
      end
      S_SCAN: begin
        if (!pend_q && j_q != count_q) begin
          pend_d = 1'b1;
        end else if (pend_q && lm_rdata != 8'h00) begin
          if (32'(j_q) < 8) abuf_d[3'(j_q)*8 +: 8] = lm_rdata;
          j_d = j_q + 1'b1;
          pend_d = 1'b0;
        end else begin
          // end of line reached: fix its length and decide on a search
          eff_d = j_q;
          alen_d = (32'(j_q) >= 8) ? 4'd8 : 4'(j_q);
          count_d = '0;
          j_d = '0;
          pend_d = 1'b0;
          mode_line_d = 1'b1;
          e_d = '0;
          lf_d = 1'b0;
          if (j_q != '0 && abuf_q[7:0] == ChPercent) state_d = S_SRCH;
          else state_d = S_CRLF;
        end
      end
      S_SRCH: begin
        if (!pend_q) begin
          if (e_q == (EW+1)'(TABLE_ENTRIES)) begin
            if (mode_line_q) begin
              state_d = S_CRLF;
            end else begin
              tm_we = 1'b1;
              valid_d[free_slot] = 1'b1;
              state_d = S_IDLE;
            end
          end else if (valid_q[e_q[EW-1:0]]) begin
            pend_d = 1'b1;
          end else begin
            e_d = e_q + 1'b1;
          end
        end else begin
          pend_d = 1'b0;
          if (entry_match(tm_rdata[63:0], abuf_q, alen_q)) begin
            pid_d = tm_rdata[67:64];
            j_d = '0;
            state_d = mode_line_q ? S_SEND : S_IDLE;
          end else begin
            e_d = e_q + 1'b1;
          end
        end
      end
      S_CRLF: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1; out_dest_d = 1'b0; out_pid_d = '0;
          out_char_d = lf_q ? ChLf : ChCr;
          out_last_d = lf_q;
          lf_d = 1'b1;
          if (lf_q) state_d = S_IDLE;
        end
      end
      S_SEND: begin
        if (!pend_q) begin
          if (!out_valid_q) pend_d = 1'b1;
        end else begin
          out_valid_d = 1'b1; out_dest_d = 1'b1; out_pid_d = pid_q;
          out_char_d = lm_rdata; out_last_d = last_char;
          j_d = j_q + 1'b1;
          pend_d = 1'b0;
          if (last_char) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      j_q         <= '0;
      e_q         <= '0;
      pend_q      <= 1'b0;
      mode_line_q <= 1'b0;
      lf_q        <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      j_q         <= j_d;
      e_q         <= e_d;
      pend_q      <= pend_d;
      mode_line_q <= mode_line_d;
      lf_q        <= lf_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eff_q      <= eff_d;
    abuf_q     <= abuf_d;
    alen_q     <= alen_d;
    owner_q    <= owner_d;
    pid_q      <= pid_d;
    out_dest_q <= out_dest_d;
    out_last_q <= out_last_d;
    out_pid_q  <= out_pid_d;
    out_char_q <= out_char_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_char_q, out_pid_q};
  assign m_axis_tuser  = out_dest_q;
  assign m_axis_tlast  = out_last_q;

  `CCLM_ASSERT(a_send_read_free, clk_i, rst_ni, !(state_q == S_SEND && pend_q) || !out_valid_q, "line read while output busy")
  `CCLM_ASSERT(a_write_free_slot, clk_i, rst_ni, !tm_we || !valid_q[free_slot], "table write over a valid entry")
  `CCLM_ASSERT_NEXT(a_cr_scans, clk_i, rst_ni, in_acc && s_axis_tuser == OpKey && key == ChCr, state_q == S_SCAN, "return did not start a line scan")

endmodule

// File: sv/cclm_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module cclm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
